// ===== hw/rtl/gcdb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcdb_pkg
// Shared constants, types and arctangent table of the great-circle distance
// and bearing pipeline.
// ----------------------------------------------------------------------------
package gcdb_pkg;

  // angle format of the ports: radians, signed, this many fraction bits
  localparam int ANGLE_FRAC_BITS = 29;
  localparam int ANGLE_W         = 32;
  localparam int DIFF_W          = ANGLE_W + 1;

  // binary angle, 2^32 units per turn
  localparam int TURN_W = 32;
  localparam logic [29:0] INV_2PI_Q32 = 30'd683565276;

  localparam int CORDIC_N = 30;
  localparam int FRAC_Q   = 30;
  localparam int TRIG_W   = 34;
  localparam int SC_Z_W   = TURN_W + 1;
  localparam logic signed [TRIG_W-1:0] INV_K_Q30 = 34'sd652032874;

  localparam int Q_W = FRAC_Q + 1;
  localparam logic [Q_W-1:0] ONE_Q30 = Q_W'(1) << FRAC_Q;

  localparam int SQRT_IN_W  = 2 * FRAC_Q + 1;
  localparam int SQRT_STEPS = (SQRT_IN_W + 1) / 2;
  localparam int SQRT_OUT_W = FRAC_Q + 1;

  localparam int ATAN_W     = 34;
  localparam int ATAN_IW    = 44;
  localparam int ATAN_Z_W   = 34;
  localparam int NORM_BIT   = 40;
  localparam int NORM_STEPS = 3;
  localparam int ATAN_LAT   = 1 + NORM_STEPS + CORDIC_N;

  localparam int TURNS_LAT = 3;
  localparam int SC_LAT    = CORDIC_N + 2;

  localparam int DIST_W = 31;
  localparam int BEAR_W = 16;
  localparam logic [31:0]       CIRC_CM       = 32'd4003017359;
  localparam logic [DIST_W-1:0] DIST_MAX      = 31'd2001508680;
  localparam logic [BEAR_W-1:0] FULL_CENTIDEG = 16'd36000;
  localparam logic [BEAR_W-1:0] BEAR_OFFSET   = 16'd9000;

  localparam int IN_W  = 2 * ANGLE_W;
  localparam int OUT_W = ((DIST_W + BEAR_W + 7) / 8) * 8;

  // input register, angle conversion, sin/cos, three product stages,
  // square root, arctangent and three scaling stages
  localparam int LATENCY  = 1 + TURNS_LAT + SC_LAT + 3 + SQRT_STEPS + ATAN_LAT + 3;
  localparam int BEAR_DLY = SQRT_STEPS + 1;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LAT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_LON = 8'd1;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage
`default_nettype wire

// ===== hw/rtl/great_circle_distance_bearing_unit.sv =====
// A result is held back only by a stalled output.
// Throughput: one fix per cycle; every stage is a register level of a single
// pipeline that advances whenever the output register is empty or being taken.
// Depth is set by the CORDIC units with their 30 iteration stages and the 31-stage square root.
// Reset (rst_n low, synchronous) empties the pipeline and clears both destination
// registers to zero.
`default_nettype none
// ----------------------------------------------------------------------------
// great_circle_distance_bearing_unit
// Haversine distance in cm and initial bearing in centidegrees (plus 90 deg)
// from a position fix to a configured destination.
// ----------------------------------------------------------------------------
module great_circle_distance_bearing_unit import gcdb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // cur_lat [31:0], cur_lon [63:32]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // dist_cm [30:0], bearing_centideg [46:31]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ANGLE_W-1:0]   cfg_data
);

  function automatic logic signed [TRIG_W-1:0] mul30(
    input logic signed [TRIG_W-1:0] a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return p[TRIG_W+FRAC_Q-1:FRAC_Q];
  endfunction

  logic en;
  logic [LATENCY-1:0] vld_r, vld_nxt;
  logic [ANGLE_W-1:0] dest_lat_r, dest_lon_r;

  // ---------------- control ----------------
  assign en        = !vld_r[LATENCY-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign vld_nxt   = {vld_r[LATENCY-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_lat_r <= '0;
      dest_lon_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DEST_LAT) begin
        dest_lat_r <= cfg_data;
      end else if (cfg_index == REG_DEST_LON) begin
        dest_lon_r <= cfg_data;
      end
    end
  end

  // ---------------- differences ----------------
  logic signed [DIFF_W-1:0] lat1_r, lat2_r, dlat_r, dlon_r;
  logic signed [DIFF_W-1:0] lat1_e, lon1_e, lat2_e, lon2_e;

  always_comb begin
    lat1_e = DIFF_W'($signed(in_tdata[ANGLE_W-1:0]));
    lon1_e = DIFF_W'($signed(in_tdata[IN_W-1:ANGLE_W]));
    lat2_e = DIFF_W'($signed(dest_lat_r));
    lon2_e = DIFF_W'($signed(dest_lon_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= lat1_e;
      lat2_r <= lat2_e;
      dlat_r <= lat2_e - lat1_e;
      dlon_r <= lon2_e - lon1_e;
    end
  end

  // ---------------- angles and sin/cos ----------------
  logic [TURN_W-1:0] t_lat1, t_lat2, t_hlat, t_hlon, t_dlon;
  logic signed [TRIG_W-1:0] s1, c1, s2, c2, shl, sho, sdo, cdo;

  gcdb_turns u_turn_lat1 (.clk(clk), .en(en), .half(1'b0), .val(lat1_r), .turn(t_lat1));
  gcdb_turns u_turn_lat2 (.clk(clk), .en(en), .half(1'b0), .val(lat2_r), .turn(t_lat2));
  gcdb_turns u_turn_hlat (.clk(clk), .en(en), .half(1'b1), .val(dlat_r), .turn(t_hlat));
  gcdb_turns u_turn_hlon (.clk(clk), .en(en), .half(1'b1), .val(dlon_r), .turn(t_hlon));
  gcdb_turns u_turn_dlon (.clk(clk), .en(en), .half(1'b0), .val(dlon_r), .turn(t_dlon));

  gcdb_sincos u_sc_lat1 (.clk(clk), .en(en), .angle(t_lat1), .sin_o(s1),  .cos_o(c1));
  gcdb_sincos u_sc_lat2 (.clk(clk), .en(en), .angle(t_lat2), .sin_o(s2),  .cos_o(c2));
  gcdb_sincos u_sc_hlat (.clk(clk), .en(en), .angle(t_hlat), .sin_o(shl), .cos_o());
  gcdb_sincos u_sc_hlon (.clk(clk), .en(en), .angle(t_hlon), .sin_o(sho), .cos_o());
  gcdb_sincos u_sc_dlon (.clk(clk), .en(en), .angle(t_dlon), .sin_o(sdo), .cos_o(cdo));

  // ---------------- products ----------------
  logic signed [TRIG_W-1:0] p1_r, pc_r, p3_r, p1d_r, p4_r;
  logic signed [TRIG_W-1:0] by_r, bt1_r, bt2_r, bcd_r, by2_r, bt1d_r, bt3_r;
  logic signed [ATAN_W-1:0] by3_r, bx_r;
  logic [SQRT_IN_W-1:0]     sqa_r, sqb_r;
  logic signed [TRIG_W:0]   a_sum, bx_sum;
  logic [Q_W-1:0]           a_cl;

  always_comb begin
    a_sum = (TRIG_W + 1)'(p1d_r) + (TRIG_W + 1)'(p4_r);
    if (a_sum[TRIG_W]) begin
      a_cl = '0;
    end else if (a_sum > $signed({{(TRIG_W - Q_W + 1){1'b0}}, ONE_Q30})) begin
      a_cl = ONE_Q30;
    end else begin
      a_cl = a_sum[Q_W-1:0];
    end
    bx_sum = (TRIG_W + 1)'(bt1d_r) - (TRIG_W + 1)'(bt3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r   <= mul30(shl, shl);
      pc_r   <= mul30(c1, c2);
      p3_r   <= mul30(sho, sho);
      by_r   <= mul30(sdo, c2);
      bt1_r  <= mul30(c1, s2);
      bt2_r  <= mul30(s1, c2);
      bcd_r  <= cdo;
      p1d_r  <= p1_r;
      p4_r   <= mul30(pc_r, p3_r);
      by2_r  <= by_r;
      bt1d_r <= bt1_r;
      bt3_r  <= mul30(bt2_r, bcd_r);
      sqa_r  <= {a_cl, {FRAC_Q{1'b0}}};
      sqb_r  <= {ONE_Q30 - a_cl, {FRAC_Q{1'b0}}};
      by3_r  <= ATAN_W'(by2_r);
      bx_r   <= bx_sum[ATAN_W-1:0];
    end
  end

  // ---------------- bearing ----------------
  logic signed [ATAN_Z_W-1:0] bz;
  logic [TURN_W+BEAR_W-1:0]   bprod_r;
  logic [TURN_W+BEAR_W:0]     brnd;
  logic [BEAR_W:0]            cd;
  logic [BEAR_W-1:0]          bear_r, bear_nxt;
  logic [BEAR_W-1:0]          bd_r [0:BEAR_DLY-1];

  gcdb_atan2 u_atan_bear (.clk(clk), .en(en), .y_in(by3_r), .x_in(bx_r), .angle(bz));

  always_comb begin
    brnd = {1'b0, bprod_r} + ((TURN_W + BEAR_W + 1)'(1) << (TURN_W - 1));
    cd   = brnd[TURN_W+BEAR_W:TURN_W];
    // a full turn after rounding wraps to zero
    if (cd >= {1'b0, FULL_CENTIDEG}) begin
      bear_nxt = BEAR_OFFSET;
    end else begin
      bear_nxt = cd[BEAR_W-1:0] + BEAR_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bprod_r <= (TURN_W + BEAR_W)'(bz[TURN_W-1:0]) * (TURN_W + BEAR_W)'(FULL_CENTIDEG);
      bear_r  <= bear_nxt;
      bd_r[0] <= bear_r;
      for (int k = 1; k < BEAR_DLY; k++) begin
        bd_r[k] <= bd_r[k-1];
      end
    end
  end

  // ---------------- distance ----------------
  logic [SQRT_OUT_W-1:0]      ra, rb;
  logic signed [ATAN_Z_W-1:0] cz;
  logic signed [ATAN_Z_W:0]   tw;
  logic [TURN_W-1:0]          theta_r, theta_nxt;
  logic [2*TURN_W-1:0]        dprod_r;
  logic [2*TURN_W:0]          drnd;
  logic [DIST_W-1:0]          dist_r, dist_nxt;

  gcdb_isqrt u_sqrt_a (.clk(clk), .en(en), .val(sqa_r), .root(ra));
  gcdb_isqrt u_sqrt_b (.clk(clk), .en(en), .val(sqb_r), .root(rb));

  gcdb_atan2 u_atan_dist (
    .clk  (clk),
    .en   (en),
    .y_in ($signed({{(ATAN_W - SQRT_OUT_W){1'b0}}, ra})),
    .x_in ($signed({{(ATAN_W - SQRT_OUT_W){1'b0}}, rb})),
    .angle(cz)
  );

  always_comb begin
    tw = {cz, 1'b0};
    // central angle limited to half a turn
    if (tw[ATAN_Z_W]) begin
      theta_nxt = '0;
    end else if (tw > $signed((ATAN_Z_W + 1)'(1) << (TURN_W - 1))) begin
      theta_nxt = TURN_W'(1) << (TURN_W - 1);
    end else begin
      theta_nxt = tw[TURN_W-1:0];
    end
    drnd = {1'b0, dprod_r} + ((2 * TURN_W + 1)'(1) << (TURN_W - 1));
    if (drnd[2*TURN_W:TURN_W] > (TURN_W + 1)'(DIST_MAX)) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = drnd[TURN_W+DIST_W-1:TURN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= theta_nxt;
      dprod_r <= (2 * TURN_W)'(theta_r) * (2 * TURN_W)'(CIRC_CM);
      dist_r  <= dist_nxt;
    end
  end

  // ---------------- output ----------------
  assign out_tvalid = vld_r[LATENCY-1];
  assign out_tdata  = {{(OUT_W - DIST_W - BEAR_W){1'b0}}, bd_r[BEAR_DLY-1], dist_r};

endmodule
`default_nettype wire

// ===== hw/rtl/gcdb_turns.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcdb_turns
// Radians to binary angle: magnitude, multiply by 2^32/(2*pi) (halved when half is set), round half away
// from zero, restore sign. Three register stages.
// ----------------------------------------------------------------------------
module gcdb_turns import gcdb_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     half,
  input  logic signed [DIFF_W-1:0] val,
  output logic [TURN_W-1:0]        turn
);

  localparam int PROD_W = DIFF_W + 30;

  logic [DIFF_W-1:0] mag_r;
  logic              neg_r, half_r, neg2_r, half2_r;
  logic [PROD_W-1:0] prod_r;
  logic [TURN_W-1:0] turn_r;
  logic [PROD_W:0]   rnd, shifted;
  logic [TURN_W-1:0] turn_nxt;

  always_comb begin
    if (half2_r) begin
      rnd     = {1'b0, prod_r} + ((PROD_W + 1)'(1) << ANGLE_FRAC_BITS);
      shifted = rnd >> (ANGLE_FRAC_BITS + 1);
    end else begin
      rnd     = {1'b0, prod_r} + ((PROD_W + 1)'(1) << (ANGLE_FRAC_BITS - 1));
      shifted = rnd >> ANGLE_FRAC_BITS;
    end
    turn_nxt = neg2_r ? TURN_W'(-shifted[TURN_W-1:0]) : shifted[TURN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= val[DIFF_W-1] ? DIFF_W'(-val) : DIFF_W'(val);
      neg_r   <= val[DIFF_W-1];
      half_r  <= half;
      prod_r  <= PROD_W'(mag_r) * PROD_W'(INV_2PI_Q32);
      neg2_r  <= neg_r;
      half2_r <= half_r;
      turn_r  <= turn_nxt;
    end
  end

  assign turn = turn_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gcdb_sincos.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcdb_sincos
// Rotation CORDIC sine and cosine of a binary angle, Q30 results. Quadrant
// fold, one iteration per stage, quadrant unfold.
// ----------------------------------------------------------------------------
module gcdb_sincos import gcdb_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [TURN_W-1:0]        angle,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  logic signed [TRIG_W-1:0] x_r [0:CORDIC_N];
  logic signed [TRIG_W-1:0] y_r [0:CORDIC_N];
  logic signed [SC_Z_W-1:0] z_r [0:CORDIC_N];
  quad_t                    q_r [0:CORDIC_N];
  logic signed [TRIG_W-1:0] sin_r, cos_r;

  logic [TURN_W-1:0] ang_plus, ang_fold;
  logic [1:0]        quad;
  logic signed [TRIG_W-1:0] sin_nxt, cos_nxt;

  always_comb begin
    ang_plus = angle + 32'h2000_0000;
    quad     = ang_plus[TURN_W-1:TURN_W-2];
    ang_fold = angle - {quad, {(TURN_W-2){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= INV_K_Q30;
      y_r[0] <= '0;
      z_r[0] <= $signed({ang_fold[TURN_W-1], ang_fold});
      q_r[0] <= quad_t'(quad);
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    logic signed [TRIG_W-1:0] dx, dy;
    logic signed [SC_Z_W-1:0] da;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = $signed({1'b0, ATAN_TURNS[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][SC_Z_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - da;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + da;
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  always_comb begin
    case (q_r[CORDIC_N])
      QUAD_0: begin
        cos_nxt = x_r[CORDIC_N];
        sin_nxt = y_r[CORDIC_N];
      end
      QUAD_1: begin
        cos_nxt = -y_r[CORDIC_N];
        sin_nxt = x_r[CORDIC_N];
      end
      QUAD_2: begin
        cos_nxt = -x_r[CORDIC_N];
        sin_nxt = -y_r[CORDIC_N];
      end
      QUAD_3: begin
        cos_nxt = y_r[CORDIC_N];
        sin_nxt = -x_r[CORDIC_N];
      end
      default: begin
        cos_nxt = x_r[CORDIC_N];
        sin_nxt = y_r[CORDIC_N];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gcdb_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcdb_isqrt
// Floor square root, restoring digit-by-digit method, one result bit per
// register stage.
// ----------------------------------------------------------------------------
module gcdb_isqrt import gcdb_pkg::*; (
  input  logic                  clk,
  input  logic                  en,
  input  logic [SQRT_IN_W-1:0]  val,
  output logic [SQRT_OUT_W-1:0] root
);

  localparam int RES_W = SQRT_IN_W + 1;

  logic [SQRT_IN_W-1:0] v_r   [0:SQRT_STEPS-1];
  logic [RES_W-1:0]     res_r [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [RES_W-1:0] BIT = RES_W'(1) << (SQRT_IN_W - 1 - 2 * k);
    logic [SQRT_IN_W-1:0] cur_v;
    logic [RES_W-1:0]     cur_res, trial;
    if (k == 0) begin : g_first
      assign cur_v   = val;
      assign cur_res = '0;
    end else begin : g_rest
      assign cur_v   = v_r[k-1];
      assign cur_res = res_r[k-1];
    end
    assign trial = cur_res + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, cur_v} >= trial) begin
          v_r[k]   <= SQRT_IN_W'({1'b0, cur_v} - trial);
          res_r[k] <= (cur_res >> 1) + BIT;
        end else begin
          v_r[k]   <= cur_v;
          res_r[k] <= cur_res >> 1;
        end
      end
    end
  end

  assign root = res_r[SQRT_STEPS-1][SQRT_OUT_W-1:0];

endmodule
`default_nettype wire

// ===== hw/rtl/gcdb_atan2.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcdb_atan2
// Vectoring CORDIC arctangent in binary angle units: half-plane fold,
// normalization in three stages, one iteration per stage.
// ----------------------------------------------------------------------------
module gcdb_atan2 import gcdb_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [ATAN_W-1:0]   y_in,
  input  logic signed [ATAN_W-1:0]   x_in,
  output logic signed [ATAN_Z_W-1:0] angle
);

  localparam int M_W = ATAN_IW - 1;
  localparam logic signed [ATAN_Z_W-1:0] Z_HALF = ATAN_Z_W'(1) << (TURN_W - 1);

  logic signed [ATAN_IW-1:0]  xn_r [0:NORM_STEPS];
  logic signed [ATAN_IW-1:0]  yn_r [0:NORM_STEPS];
  logic [M_W-1:0]             mn_r [0:NORM_STEPS];
  logic [NORM_STEPS:0]        flip_r;
  logic [ATAN_LAT-1:0]        zero_r;
  logic signed [ATAN_IW-1:0]  x_r [0:CORDIC_N-1];
  logic signed [ATAN_IW-1:0]  y_r [0:CORDIC_N-1];
  logic signed [ATAN_Z_W-1:0] z_r [0:CORDIC_N-1];

  logic signed [ATAN_IW-1:0] xe, ye, xf, yf, ya;

  // fold into the right half plane
  always_comb begin
    xe = ATAN_IW'(x_in);
    ye = ATAN_IW'(y_in);
    xf = x_in[ATAN_W-1] ? -xe : xe;
    yf = x_in[ATAN_W-1] ? -ye : ye;
    ya = yf[ATAN_IW-1] ? -yf : yf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r[0]   <= xf;
      yn_r[0]   <= yf;
      mn_r[0]   <= M_W'(xf | ya);
      flip_r[0] <= x_in[ATAN_W-1];
      zero_r    <= {zero_r[ATAN_LAT-2:0], (x_in == '0) && (y_in == '0)};
    end
  end

  // double both until one magnitude reaches bit NORM_BIT
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SA = 32 >> (2 * j);
    localparam int SB = SA >> 1;
    localparam logic [M_W-1:0] LIM_A = M_W'(1) << (NORM_BIT + 1 - SA);
    localparam logic [M_W-1:0] LIM_B = M_W'(1) << (NORM_BIT + 1 - SB);
    logic signed [ATAN_IW-1:0] xa, yb_a, xb, yb;
    logic [M_W-1:0]            ma, mb;
    always_comb begin
      if (mn_r[j] < LIM_A) begin
        xa   = xn_r[j] <<< SA;
        yb_a = yn_r[j] <<< SA;
        ma   = mn_r[j] << SA;
      end else begin
        xa   = xn_r[j];
        yb_a = yn_r[j];
        ma   = mn_r[j];
      end
      if (ma < LIM_B) begin
        xb = xa <<< SB;
        yb = yb_a <<< SB;
        mb = ma << SB;
      end else begin
        xb = xa;
        yb = yb_a;
        mb = ma;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xn_r[j+1]   <= xb;
        yn_r[j+1]   <= yb;
        mn_r[j+1]   <= mb;
        flip_r[j+1] <= flip_r[j];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    logic signed [ATAN_IW-1:0]  xs, ys, dx, dy;
    logic signed [ATAN_Z_W-1:0] zs, da;
    if (i == 0) begin : g_first
      assign xs = xn_r[NORM_STEPS];
      assign ys = yn_r[NORM_STEPS];
      assign zs = flip_r[NORM_STEPS] ? Z_HALF : '0;
    end else begin : g_rest
      assign xs = x_r[i-1];
      assign ys = y_r[i-1];
      assign zs = z_r[i-1];
    end
    assign dx = ys >>> i;
    assign dy = xs >>> i;
    assign da = $signed({2'b00, ATAN_TURNS[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys > 0) begin
          x_r[i] <= xs + dx;
          y_r[i] <= ys - dy;
          z_r[i] <= zs + da;
        end else begin
          x_r[i] <= xs - dx;
          y_r[i] <= ys + dy;
          z_r[i] <= zs - da;
        end
      end
    end
  end

  // both operands zero gives angle zero
  assign angle = zero_r[ATAN_LAT-1] ? '0 : z_r[CORDIC_N-1];

endmodule
`default_nettype wire
